/* rtl/tsrs_pkg.sv */
package tsrs_pkg;

  localparam int SWEEP_STEPS = 20;

  localparam int CLK_W   = 32;
  localparam int FREQ_W  = 16;
  localparam int MS_W    = 20;
  localparam int RELOAD_W = 16;

  localparam logic [CLK_W-1:0] CLK_HZ_RESET = CLK_W'(1193182);

  // step index counts 0 .. SWEEP_STEPS-1
  localparam int IDX_W = $clog2(SWEEP_STEPS + 1);

  // restoring divider: one quotient bit per cycle over the whole dividend
  localparam int DCNT_W = $clog2(CLK_W);

endpackage

/* rtl/tsrs_if.sv */
interface tsrs_req_if;
  import tsrs_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [FREQ_W-1:0] first_freq_hz;
  logic [FREQ_W-1:0] final_freq_hz;
  logic [MS_W-1:0]   length_ms;

  modport source (output valid, req_type, first_freq_hz, final_freq_hz, length_ms,
                  input ready);
  modport sink (input valid, req_type, first_freq_hz, final_freq_hz, length_ms,
                output ready);
endinterface

interface tsrs_cmd_if;
  import tsrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [RELOAD_W-1:0] reload_value;
  logic                reload_write;
  logic                reload_overflow;
  logic                speaker_gate;
  logic [MS_W-1:0]     hold_ms;
  logic                last;

  modport source (output valid, reload_value, reload_write, reload_overflow,
                  speaker_gate, hold_ms, last, input ready);
  modport sink (input valid, reload_value, reload_write, reload_overflow,
                speaker_gate, hold_ms, last, output ready);
endinterface

interface tsrs_cfg_if;
  import tsrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CLK_W-1:0] timer_clock_hz;

  modport source (output valid, timer_clock_hz, input ready);
  modport sink (input valid, timer_clock_hz, output ready);
endinterface

/* rtl/tone_sweep_reload_sequencer_unit.sv */
// Tone / sweep command sequencer.
// in_ch: one beat per request (single tone or linear sweep). The block takes a
//   request only when idle and holds in_ch.ready low until the request's last
//   command beat has left on out_ch.
// out_ch: speaker commands, one output register; the final one of a request
//   carries last. A tone gives one or two commands, a sweep SWEEP_STEPS + 1.
// cfg_ch: timer clock rate, always ready; write it only between requests.
// Timing: every command with a nonzero frequency goes through one shared
//   restoring divider at one quotient bit per cycle, entered from a launch
//   state and followed by the output state. A sweep first runs the divider twice
//   more (hold time and step size).
// Stall: while out_ch.ready is low the command stays in the output register
//   and the sequencer waits; nothing is dropped.
// Reset: the timer clock register returns to 1193182 Hz, the sequencer goes
//   idle and out_ch.valid drops.
module tone_sweep_reload_sequencer_unit (
  input logic      clk,
  input logic      rst_n,
  tsrs_req_if.sink in_ch,
  tsrs_cmd_if.source out_ch,
  tsrs_cfg_if.sink cfg_ch
);
  import tsrs_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_LAUNCH = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  localparam logic [1:0] P_HOLD = 2'd0;
  localparam logic [1:0] P_STEP = 2'd1;
  localparam logic [1:0] P_CMD  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          purp_r, purp_nxt;
  logic [CLK_W-1:0]    clk_hz_r, clk_hz_nxt;

  // divider
  logic [CLK_W-1:0]    quo_r, quo_nxt;
  logic [FREQ_W-1:0]   rem_r, rem_nxt;
  logic [FREQ_W-1:0]   dvs_r, dvs_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;

  // request context
  logic                type_r, type_nxt;
  logic [FREQ_W-1:0]   first_r, first_nxt;
  logic [FREQ_W-1:0]   final_r, final_nxt;
  logic [FREQ_W-1:0]   freq_r, freq_nxt;
  logic [FREQ_W-1:0]   step_r, step_nxt;
  logic [MS_W-1:0]     hold_r, hold_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  // output register
  logic                ov_r, ov_nxt;
  logic [RELOAD_W-1:0] o_reload_r, o_reload_nxt;
  logic                o_wr_r, o_wr_nxt;
  logic                o_ovf_r, o_ovf_nxt;
  logic                o_gate_r, o_gate_nxt;
  logic [MS_W-1:0]     o_hold_r, o_hold_nxt;
  logic                o_last_r, o_last_nxt;

  // one divider step
  logic [FREQ_W:0]     shifted;
  logic                take;
  logic [FREQ_W:0]     trial;
  logic [CLK_W-1:0]    quo_step;
  logic [FREQ_W-1:0]   rem_step;

  logic [FREQ_W:0]     diff;
  logic [FREQ_W:0]     diff_mag;

  assign shifted  = {rem_r, quo_r[CLK_W-1]};
  assign take     = shifted >= {1'b0, dvs_r};
  assign trial    = shifted - {1'b0, dvs_r};
  assign quo_step = {quo_r[CLK_W-2:0], take};
  assign rem_step = take ? trial[FREQ_W-1:0] : shifted[FREQ_W-1:0];

  assign diff     = {1'b0, final_r} - {1'b0, first_r};
  assign diff_mag = diff[FREQ_W] ? (~diff + 1'b1) : diff;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = ov_r;
  assign out_ch.reload_value    = o_reload_r;
  assign out_ch.reload_write    = o_wr_r;
  assign out_ch.reload_overflow = o_ovf_r;
  assign out_ch.speaker_gate    = o_gate_r;
  assign out_ch.hold_ms         = o_hold_r;
  assign out_ch.last            = o_last_r;

  always_comb begin
    state_nxt    = state_r;
    purp_nxt     = purp_r;
    clk_hz_nxt   = clk_hz_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    dcnt_nxt     = dcnt_r;
    type_nxt     = type_r;
    first_nxt    = first_r;
    final_nxt    = final_r;
    freq_nxt     = freq_r;
    step_nxt     = step_r;
    hold_nxt     = hold_r;
    idx_nxt      = idx_r;
    ov_nxt       = ov_r;
    o_reload_nxt = o_reload_r;
    o_wr_nxt     = o_wr_r;
    o_ovf_nxt    = o_ovf_r;
    o_gate_nxt   = o_gate_r;
    o_hold_nxt   = o_hold_r;
    o_last_nxt   = o_last_r;

    if (cfg_ch.valid) begin
      clk_hz_nxt = cfg_ch.timer_clock_hz;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          type_nxt  = in_ch.req_type;
          first_nxt = in_ch.first_freq_hz;
          final_nxt = in_ch.final_freq_hz;
          if (!in_ch.req_type) begin
            if (in_ch.first_freq_hz == '0) begin
              // silent tone: single gate-off hold
              ov_nxt       = 1'b1;
              o_reload_nxt = '0;
              o_wr_nxt     = 1'b0;
              o_ovf_nxt    = 1'b0;
              o_gate_nxt   = 1'b0;
              o_hold_nxt   = in_ch.length_ms;
              o_last_nxt   = 1'b1;
              state_nxt    = S_OUT;
            end else begin
              freq_nxt  = in_ch.first_freq_hz;
              hold_nxt  = in_ch.length_ms;
              state_nxt = S_LAUNCH;
            end
          end else begin
            quo_nxt   = CLK_W'(in_ch.length_ms);
            rem_nxt   = '0;
            dvs_nxt   = FREQ_W'(SWEEP_STEPS);
            dcnt_nxt  = '0;
            purp_nxt  = P_HOLD;
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(CLK_W - 1)) begin
          unique case (purp_r)
            P_HOLD: begin
              hold_nxt = quo_step[MS_W-1:0];
              quo_nxt  = CLK_W'(diff_mag);
              rem_nxt  = '0;
              dcnt_nxt = '0;
              purp_nxt = P_STEP;
            end
            P_STEP: begin
              // truncate toward zero: divide the magnitude, then restore sign
              step_nxt  = diff[FREQ_W] ? (~quo_step[FREQ_W-1:0] + 1'b1)
                                       : quo_step[FREQ_W-1:0];
              freq_nxt  = first_r;
              idx_nxt   = '0;
              state_nxt = S_LAUNCH;
            end
            P_CMD: begin
              ov_nxt       = 1'b1;
              o_reload_nxt = quo_step[RELOAD_W-1:0];
              o_wr_nxt     = 1'b1;
              o_ovf_nxt    = |quo_step[CLK_W-1:RELOAD_W];
              o_gate_nxt   = 1'b1;
              o_hold_nxt   = hold_r;
              o_last_nxt   = 1'b0;
              state_nxt    = S_OUT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_LAUNCH: begin
        if (freq_r == '0) begin
          // zero step frequency inside a sweep: gate stays on, no reload
          ov_nxt       = 1'b1;
          o_reload_nxt = '0;
          o_wr_nxt     = 1'b0;
          o_ovf_nxt    = 1'b0;
          o_gate_nxt   = 1'b1;
          o_hold_nxt   = hold_r;
          o_last_nxt   = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          quo_nxt   = clk_hz_r;
          rem_nxt   = '0;
          dvs_nxt   = freq_r;
          dcnt_nxt  = '0;
          purp_nxt  = P_CMD;
          state_nxt = S_DIV;
        end
      end

      S_OUT: begin
        if (out_ch.ready) begin
          ov_nxt = 1'b0;
          if (o_last_r) begin
            state_nxt = S_IDLE;
          end else if (!type_r || idx_r == IDX_W'(SWEEP_STEPS - 1)) begin
            // closing gate-off beat
            ov_nxt       = 1'b1;
            o_reload_nxt = '0;
            o_wr_nxt     = 1'b0;
            o_ovf_nxt    = 1'b0;
            o_gate_nxt   = 1'b0;
            o_hold_nxt   = '0;
            o_last_nxt   = 1'b1;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            freq_nxt  = freq_r + step_r;
            state_nxt = S_LAUNCH;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ov_r     <= 1'b0;
      clk_hz_r <= CLK_HZ_RESET;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      clk_hz_r <= clk_hz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    purp_r     <= purp_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    dcnt_r     <= dcnt_nxt;
    type_r     <= type_nxt;
    first_r    <= first_nxt;
    final_r    <= final_nxt;
    freq_r     <= freq_nxt;
    step_r     <= step_nxt;
    hold_r     <= hold_nxt;
    idx_r      <= idx_nxt;
    o_reload_r <= o_reload_nxt;
    o_wr_r     <= o_wr_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_gate_r   <= o_gate_nxt;
    o_hold_r   <= o_hold_nxt;
    o_last_r   <= o_last_nxt;
  end

endmodule
